[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rte_pkg.sv]
package rte_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int TIME_W        = 32;
  localparam int GAIN_W        = 17;
  localparam int GAIN_SHIFT    = 16;
  localparam int DIGIT_W       = 16;
  localparam int DEV_SHIFT     = 2;
  localparam int TIMEOUT_W     = 9;
  localparam int CFG_IDX_W     = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE           = 17'h10000;
  localparam logic [GAIN_W-1:0] ESTIMATE_GAIN_RST  = 17'd8192;
  localparam logic [GAIN_W-1:0] DEVIATION_GAIN_RST = 17'd16384;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN = 9'd100;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = 9'd300;

  localparam logic [CFG_IDX_W-1:0] REG_ESTIMATE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_GAIN = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } rte_mul_status_t;

endpackage

[hw/rtl/rte_sample_if.sv]
interface rte_sample_if import rte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] send_time;
  logic [TIME_W-1:0] ack_time;

  modport source (output valid, output send_time, output ack_time, input ready);
  modport sink (input valid, input send_time, input ack_time, output ready);
endinterface

[hw/rtl/rte_result_if.sv]
interface rte_result_if import rte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TIMEOUT_W-1:0]     timeout_ms;
  logic signed [TIME_W-1:0] smoothed_rtt;
  logic [TIME_W-1:0]        rtt_deviation;

  modport source (output valid, output timeout_ms, output smoothed_rtt,
                  output rtt_deviation, input ready);
  modport sink (input valid, input timeout_ms, input smoothed_rtt,
                input rtt_deviation, output ready);
endinterface

[hw/rtl/rte_cfg_if.sv]
interface rte_cfg_if import rte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/rte_mul.sv]
`include "assert_macros.svh"

module rte_mul import rte_pkg::*; #(
  parameter int MAG_W = TIME_W + FRAC_BITS_DEF,
  localparam int NDIG = (MAG_W + DIGIT_W - 1) / DIGIT_W,
  localparam int PROD_W = NDIG * DIGIT_W + GAIN_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     negate,
  input  logic [GAIN_W-1:0]        gain,
  input  logic [MAG_W-1:0]         magnitude,
  output rte_mul_status_t          status,
  output logic signed [PROD_W-1:0] product
);

  localparam int PAD_W = NDIG * DIGIT_W;
  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [PAD_W-1:0]            opnd;
  logic [GAIN_W-1:0]           g;
  logic                        neg;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;
  logic signed [PROD_W-1:0]    acc;

  logic [DIGIT_W-1:0]          digit;
  logic [GAIN_W+DIGIT_W-1:0]   pp_u;
  logic signed [PROD_W-1:0]    pp;
  logic signed [PROD_W-1:0]    acc_shift;
  logic signed [PROD_W-1:0]    acc_next;

  // most significant digit first, horner accumulation
  assign digit     = opnd[cnt*DIGIT_W +: DIGIT_W];
  assign pp_u      = g * digit;
  assign pp        = signed'(PROD_W'(pp_u));
  assign acc_shift = acc <<< DIGIT_W;
  assign acc_next  = neg ? (acc_shift - pp) : (acc_shift + pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opnd <= PAD_W'(magnitude);
        g    <= gain;
        neg  <= negate;
        acc  <= '0;
        cnt  <= CNT_W'(NDIG - 1);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign status  = '{busy: busy, done: done};
  assign product = acc;

  `ASSERT_IMPLIES(a_no_start_busy, clk, rst, busy, !start, "start while busy")
  `ASSERT_NEXT(a_done_after_last, clk, rst, busy && cnt == '0, done && !busy, "done missing")

endmodule

[hw/rtl/retransmit_timeout_estimator.sv]
// a sample transaction leads to result valid through the estimate multiply, the deviation multiply
//   and the timeout sum, and the result waits while the previous result is still held
// a new sample is accepted only in the idle state, after the previous result has been loaded;
//   the shared 17x16 multiply-accumulate unit is run twice per sample
// reset: gains to 8192 and 16384, estimate and deviation to zero, no result pending
`include "assert_macros.svh"

module retransmit_timeout_estimator import rte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rte_cfg_if.sink      cfg,
  rte_sample_if.sink   sample,
  rte_result_if.source result
);

  localparam int MAG_W  = TIME_W + FRAC_BITS;
  localparam int EST_W  = MAG_W;
  localparam int DEV_W  = MAG_W;
  localparam int AW     = MAG_W + GAIN_SHIFT + 2;
  localparam int TQ_W   = AW - FRAC_BITS;
  localparam int NDIG   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PROD_W = NDIG * DIGIT_W + GAIN_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EST_DIFF,
    S_EST_MUL,
    S_EST_WAIT,
    S_EST_TRUNC,
    S_ERR_DIFF,
    S_ERR_ABS,
    S_DEV_DIFF,
    S_DEV_MUL,
    S_DEV_WAIT,
    S_DEV_SHIFT,
    S_TO_SUM,
    S_TO_TRUNC,
    S_FIN
  } state_t;

  state_t                   state;
  logic [GAIN_W-1:0]        est_gain;
  logic [GAIN_W-1:0]        dev_gain;
  logic signed [TIME_W-1:0] rtt;
  logic signed [EST_W-1:0]  rtt_estimate;
  logic [DEV_W-1:0]         rtt_spread;
  logic signed [AW-1:0]     acc;
  logic [TIME_W-1:0]        err;
  logic [TQ_W-1:0]          tq;
  logic                     out_valid;
  logic [TIMEOUT_W-1:0]     out_timeout;
  logic signed [TIME_W-1:0] out_smoothed;
  logic [TIME_W-1:0]        out_dev;

  logic [GAIN_W-1:0]        est_gain_eff;
  logic [GAIN_W-1:0]        dev_gain_eff;
  logic [GAIN_W-1:0]        mul_gain;
  logic                     mul_start;
  rte_mul_status_t          mul_stat;
  logic signed [PROD_W-1:0] mul_prod;
  logic signed [AW-1:0]     prod_ext;
  logic signed [AW-1:0]     r_ext;
  logic signed [AW-1:0]     e_ext;
  logic [AW-1:0]            d_ext;
  logic [AW-1:0]            err_ext;
  logic [AW-1:0]            acc_mag;
  logic signed [AW-1:0]     gain_bias;
  logic signed [AW-1:0]     frac_bias;
  logic signed [AW-1:0]     est_sum;
  logic signed [AW-1:0]     t_sum;
  logic signed [EST_W-1:0]  e_bias;
  logic signed [EST_W-1:0]  e_sum;
  logic [TIMEOUT_W-1:0]     timeout_clamped;
  logic                     out_free;

  // gain above one acts as one
  assign est_gain_eff = est_gain[GAIN_W-1] ? GAIN_ONE : est_gain;
  assign dev_gain_eff = dev_gain[GAIN_W-1] ? GAIN_ONE : dev_gain;
  assign mul_gain     = (state == S_EST_MUL) ? est_gain_eff : dev_gain_eff;
  assign mul_start    = (state == S_EST_MUL) || (state == S_DEV_MUL);

  assign prod_ext = signed'(mul_prod[AW-1:0]);
  assign r_ext    = AW'(rtt) <<< FRAC_BITS;
  assign e_ext    = AW'(rtt_estimate);
  assign d_ext    = AW'(rtt_spread);
  assign err_ext  = AW'(err);
  assign acc_mag  = acc[AW-1] ? (~acc + 1'b1) : acc;

  // truncation toward zero of signed values
  assign gain_bias = acc[AW-1] ? AW'(GAIN_ONE - 1'b1) : '0;
  assign frac_bias = acc[AW-1] ? AW'((1 << FRAC_BITS) - 1) : '0;
  assign est_sum   = acc + gain_bias;
  assign t_sum     = acc + frac_bias;
  assign e_bias    = rtt_estimate[EST_W-1] ? EST_W'((1 << FRAC_BITS) - 1) : '0;
  assign e_sum     = rtt_estimate + e_bias;

  always_comb begin
    if (tq[TQ_W-1] || (tq < TQ_W'(TIMEOUT_MIN))) begin
      timeout_clamped = TIMEOUT_MIN;
    end else if (tq > TQ_W'(TIMEOUT_MAX)) begin
      timeout_clamped = TIMEOUT_MAX;
    end else begin
      timeout_clamped = tq[TIMEOUT_W-1:0];
    end
  end

  assign out_free = !out_valid || result.ready;

  rte_mul #(
    .MAG_W (MAG_W)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .negate    (acc[AW-1]),
    .gain      (mul_gain),
    .magnitude (acc_mag[MAG_W-1:0]),
    .status    (mul_stat),
    .product   (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      est_gain     <= ESTIMATE_GAIN_RST;
      dev_gain     <= DEVIATION_GAIN_RST;
      rtt_estimate <= '0;
      rtt_spread   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_ESTIMATE_GAIN:  est_gain <= cfg.data;
          REG_DEVIATION_GAIN: dev_gain <= cfg.data;
          default: ;
        endcase
      end

      if (result.valid && result.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            rtt   <= signed'(sample.ack_time - sample.send_time);
            state <= S_EST_DIFF;
          end
        end
        S_EST_DIFF: begin
          acc   <= r_ext - e_ext;
          state <= S_EST_MUL;
        end
        S_EST_MUL: begin
          state <= S_EST_WAIT;
        end
        S_EST_WAIT: begin
          if (mul_stat.done) begin
            acc   <= (e_ext <<< GAIN_SHIFT) + prod_ext;
            state <= S_EST_TRUNC;
          end
        end
        S_EST_TRUNC: begin
          rtt_estimate <= est_sum[GAIN_SHIFT +: EST_W];
          state        <= S_ERR_DIFF;
        end
        S_ERR_DIFF: begin
          acc   <= r_ext - e_ext;
          state <= S_ERR_ABS;
        end
        S_ERR_ABS: begin
          err   <= acc_mag[FRAC_BITS +: TIME_W];
          state <= S_DEV_DIFF;
        end
        S_DEV_DIFF: begin
          acc   <= signed'(err_ext << FRAC_BITS) - signed'(d_ext);
          state <= S_DEV_MUL;
        end
        S_DEV_MUL: begin
          state <= S_DEV_WAIT;
        end
        S_DEV_WAIT: begin
          if (mul_stat.done) begin
            acc   <= signed'(d_ext << GAIN_SHIFT) + prod_ext;
            state <= S_DEV_SHIFT;
          end
        end
        S_DEV_SHIFT: begin
          rtt_spread <= acc[GAIN_SHIFT +: DEV_W];
          state      <= S_TO_SUM;
        end
        S_TO_SUM: begin
          acc   <= e_ext + signed'(d_ext << DEV_SHIFT);
          state <= S_TO_TRUNC;
        end
        S_TO_TRUNC: begin
          tq    <= t_sum[FRAC_BITS +: TQ_W];
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_timeout  <= timeout_clamped;
            out_smoothed <= e_sum[FRAC_BITS +: TIME_W];
            out_dev      <= rtt_spread[FRAC_BITS +: TIME_W];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg.ready            = 1'b1;
  assign sample.ready         = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.timeout_ms    = out_timeout;
  assign result.smoothed_rtt  = out_smoothed;
  assign result.rtt_deviation = out_dev;

  `ASSERT_IMPLIES(a_done_in_wait, clk, rst, mul_stat.done,
                  (state == S_EST_WAIT) || (state == S_DEV_WAIT),
                  "product arrived outside a wait state")
  `ASSERT_IMPLIES(a_load_from_fin, clk, rst, $rose(out_valid), $past(state) == S_FIN,
                  "result loaded outside final step")
  `ASSERT_IMPLIES(a_timeout_range, clk, rst, out_valid,
                  (out_timeout >= TIMEOUT_MIN) && (out_timeout <= TIMEOUT_MAX),
                  "timeout out of range")

endmodule
